>>> rtl/button_lockout_debouncer_top_defines.svh
// Assertion macros for the button lockout debouncer.
// Included by the top-level RTL, which carries the concurrent assertions; no dependencies.
`ifndef BUTTON_LOCKOUT_DEBOUNCER_TOP_DEFINES_SVH
`define BUTTON_LOCKOUT_DEBOUNCER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BLD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bld_pkg.sv
// Shared types and constants of the button lockout debouncer.
// No dependencies; used by the interfaces, bld_core and the top level.
`default_nettype none

package bld_pkg;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_INVERT_LEVEL  = 2'd0;
  localparam cfg_idx_t CFG_DEBOUNCE_TIME = 2'd1;
  localparam cfg_idx_t CFG_HOLD_TIME     = 2'd2;

  localparam logic [31:0] DEBOUNCE_TIME_RESET = 32'd25;
  localparam logic [31:0] HOLD_TIME_RESET     = 32'd1000;

  typedef struct packed {
    logic        invert_level;
    logic [31:0] debounce_time;
    logic [31:0] hold_time;
  } cfg_t;

  typedef struct packed {
    logic        pressed_now;
    logic        press_edge;
    logic        release_edge;
    logic        held_pressed;
    logic        held_released;
    logic [31:0] change_time;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/bld_if.sv
// Valid/ready channel interfaces: sample input, result output, register writes.
// Depends on bld_pkg.
`default_nettype none

interface bld_sample_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        pin_level;

  modport source (output valid, output now_ms, output pin_level, input ready);
  modport sink   (input valid, input now_ms, input pin_level, output ready);
endinterface

interface bld_result_if;
  logic        valid;
  logic        ready;
  logic        pressed_now;
  logic        press_edge;
  logic        release_edge;
  logic        held_pressed;
  logic        held_released;
  logic [31:0] change_time;

  modport source (output valid, output pressed_now, output press_edge,
                  output release_edge, output held_pressed, output held_released,
                  output change_time, input ready);
  modport sink   (input valid, input pressed_now, input press_edge,
                  input release_edge, input held_pressed, input held_released,
                  input change_time, output ready);
endinterface

interface bld_cfg_if;
  logic               valid;
  logic               ready;
  bld_pkg::cfg_idx_t  index;
  logic [31:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/bld_core.sv
// Debounce step: lockout check, state update and held flags for one sample.
// Depends on bld_pkg.
`default_nettype none

module bld_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  bld_pkg::cfg_t          cfg,
  input  logic [31:0]            now_ms,
  input  logic                   pin_level,
  input  logic                   stable_level,
  input  logic [TIME_BITS-1:0]   last_change_stamp,
  output logic                   stable_level_next,
  output logic [TIME_BITS-1:0]   last_change_stamp_next,
  output bld_pkg::result_t       res
);
  import bld_pkg::*;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] debounce_t;
  logic [TIME_BITS-1:0] hold_t;
  logic [TIME_BITS-1:0] since;
  logic                 level;
  logic                 unlocked;
  logic                 changed;
  logic                 held;

  assign now_t      = TIME_BITS'(now_ms);
  assign debounce_t = TIME_BITS'(cfg.debounce_time);
  assign hold_t     = TIME_BITS'(cfg.hold_time);
  assign level      = pin_level ^ cfg.invert_level;

  // modular elapsed time since last accepted change
  assign since    = now_t - last_change_stamp;
  assign unlocked = (since >= debounce_t);
  assign changed  = unlocked && (level != stable_level);

  assign stable_level_next      = unlocked ? level : stable_level;
  assign last_change_stamp_next = changed ? now_t : last_change_stamp;

  // on a change the elapsed time restarts at zero
  assign held = changed ? (hold_t == '0) : (since >= hold_t);

  always_comb begin
    res.pressed_now   = stable_level_next;
    res.press_edge    = changed && stable_level_next;
    res.release_edge  = changed && !stable_level_next;
    res.held_pressed  = stable_level_next && held;
    res.held_released = !stable_level_next && held;
    res.change_time   = 32'(last_change_stamp_next);
  end

endmodule

`default_nettype wire

>>> rtl/button_lockout_debouncer_top.sv
// A sample accepted into the input stage moves on to the result register when the result stage advances.
// Throughput: one sample per cycle while the result channel does not stall; the debounce state is read and written
// in the single compute stage, so each sample sees the state left by the one before.
// Reset (rst, synchronous): button released, change time zero, lockout 25,
// hold 1000, no inversion; both pipeline stages empty, no channel ready.
`default_nettype none

module button_lockout_debouncer_top #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  bld_sample_if.sink    sample,
  bld_result_if.source  result,
  bld_cfg_if.sink       cfg
);
  import bld_pkg::*;

`include "button_lockout_debouncer_top_defines.svh"

  // configuration registers
  cfg_t                 cfg_reg;

  // input stage
  logic                 s_valid;
  logic [31:0]          s_now_ms;
  logic                 s_pin_level;

  // debounce state
  logic                 stable_level;
  logic [TIME_BITS-1:0] last_change_stamp;
  logic                 stable_level_next;
  logic [TIME_BITS-1:0] last_change_stamp_next;

  // result stage
  logic                 o_valid;
  result_t              o_res;
  result_t              res_next;

  logic                 advance;
  logic                 sample_ready;

  // result stage frees when empty or being taken
  assign advance      = !o_valid || result.ready;
  // nothing is taken while reset is held
  assign sample_ready = !rst && (!s_valid || advance);
  assign sample.ready = sample_ready;
  assign cfg.ready    = !rst;

  bld_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .cfg                    (cfg_reg),
    .now_ms                 (s_now_ms),
    .pin_level              (s_pin_level),
    .stable_level           (stable_level),
    .last_change_stamp      (last_change_stamp),
    .stable_level_next      (stable_level_next),
    .last_change_stamp_next (last_change_stamp_next),
    .res                    (res_next)
  );

  // control, state and config
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid               <= 1'b0;
      o_valid               <= 1'b0;
      stable_level          <= 1'b0;
      last_change_stamp     <= '0;
      cfg_reg.invert_level  <= 1'b0;
      cfg_reg.debounce_time <= DEBOUNCE_TIME_RESET;
      cfg_reg.hold_time     <= HOLD_TIME_RESET;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_INVERT_LEVEL:  cfg_reg.invert_level  <= cfg.data[0];
          CFG_DEBOUNCE_TIME: cfg_reg.debounce_time <= cfg.data;
          CFG_HOLD_TIME:     cfg_reg.hold_time     <= cfg.data;
          default: ;
        endcase
      end
      if (sample_ready) begin
        s_valid <= sample.valid;
      end
      if (advance) begin
        o_valid <= s_valid;
        if (s_valid) begin
          stable_level      <= stable_level_next;
          last_change_stamp <= last_change_stamp_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (sample.valid && sample_ready) begin
      s_now_ms    <= sample.now_ms;
      s_pin_level <= sample.pin_level;
    end
    if (advance && s_valid) begin
      o_res <= res_next;
    end
  end

  assign result.valid         = o_valid;
  assign result.pressed_now   = o_res.pressed_now;
  assign result.press_edge    = o_res.press_edge;
  assign result.release_edge  = o_res.release_edge;
  assign result.held_pressed  = o_res.held_pressed;
  assign result.held_released = o_res.held_released;
  assign result.change_time   = o_res.change_time;

  // a pending item in the input stage is never dropped while the output stalls
  `BLD_ASSERT_NEXT(a_hold_stage, clk, rst, s_valid && !advance, s_valid, "input stage item lost")
  // state only moves when an item is processed
  `BLD_ASSERT_NEXT(a_state_stable, clk, rst, !(advance && s_valid), $stable(stable_level) && $stable(last_change_stamp), "debounce state moved without item")
  // an edge in a fresh result matches the state change that produced it
  `BLD_ASSERT_NEXT(a_edge_match, clk, rst, advance && s_valid, (stable_level != $past(stable_level)) == (o_res.press_edge || o_res.release_edge), "edge flag disagrees with state change")
  // shown result agrees with the stored state it left behind
  `BLD_ASSERT_NOW(a_result_state, clk, rst, o_valid && !s_valid, o_res.pressed_now == stable_level, "result level differs from stored state")

endmodule

`default_nettype wire

>>> dv/tb_button_lockout_debouncer_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for button_lockout_debouncer_top: directed table, then random phases.
// Depends on bld_pkg, the channel interfaces in bld_if.sv and the top-level RTL.
`default_nettype none

module tb_button_lockout_debouncer_top;
  import bld_pkg::*;

  localparam int unsigned TIME_BITS    = 32;
  localparam int          LIMIT_CYCLES = 200000;
  localparam int          NUM_PHASES   = 8;
  localparam int          PHASE_ITEMS  = 142;
  localparam int          MAX_REPORTS  = 10;

  // Index 3 decodes to no register; writes there must leave the block alone.
  localparam cfg_idx_t CFG_UNUSED = 2'd3;

  // One row of the directed table: either a register write or a sample.
  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_idx_t    idx;
    logic [31:0] val;      // write data, or the sample's timestamp
    logic        pin;
    logic        typed;    // 1: expected result below is authoritative
    result_t     want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  bld_sample_if smp ();
  bld_result_if res ();
  bld_cfg_if    cfgc ();

  button_lockout_debouncer_top #(.TIME_BITS(TIME_BITS)) dut (
    .clk    (clk),
    .rst    (rst),
    .sample (smp),
    .result (res),
    .cfg    (cfgc)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Debouncer mirror: configuration and state as the block should hold them.
  logic        m_invert;
  logic [31:0] m_debounce;
  logic [31:0] m_hold;
  logic        m_level;
  logic [31:0] m_stamp;

  result_t pending_results[$];
  int      mismatches = 0;

  // Per-side idling switches; turned off in some phases to get back-to-back traffic.
  bit src_idle = 1'b1;
  bit snk_idle = 1'b1;

  // Advance the mirror by one sample and return what the block should report.
  function automatic result_t debounce_step(logic [31:0] now, logic pin);
    result_t     r;
    logic        lvl;
    logic        chg;
    logic [31:0] since;
    logic [31:0] age;
    lvl   = pin ^ m_invert;
    chg   = 1'b0;
    since = now - m_stamp;
    // Outside the lockout window the sample becomes the debounced level.
    if (since >= m_debounce) begin
      if (lvl != m_level) begin
        chg     = 1'b1;
        m_stamp = now;
      end
      m_level = lvl;
    end
    // Held flags are evaluated even while locked out.
    age             = now - m_stamp;
    r.pressed_now   = m_level;
    r.press_edge    = chg & m_level;
    r.release_edge  = chg & ~m_level;
    r.held_pressed  = m_level & (age >= m_hold);
    r.held_released = ~m_level & (age >= m_hold);
    r.change_time   = m_stamp;
    return r;
  endfunction

  function automatic result_t outcome(logic p, logic pe, logic re, logic hp, logic hr,
                                      logic [31:0] ct);
    result_t r;
    r.pressed_now   = p;
    r.press_edge    = pe;
    r.release_edge  = re;
    r.held_pressed  = hp;
    r.held_released = hr;
    r.change_time   = ct;
    return r;
  endfunction

  function automatic dir_row_t typed_row(logic [31:0] now, logic pin, result_t want);
    return '{kind: ROW_SAMPLE, idx: CFG_INVERT_LEVEL, val: now, pin: pin, typed: 1'b1,
             want: want};
  endfunction

  function automatic dir_row_t sample_row(logic [31:0] now, logic pin);
    return '{kind: ROW_SAMPLE, idx: CFG_INVERT_LEVEL, val: now, pin: pin, typed: 1'b0,
             want: '0};
  endfunction

  function automatic dir_row_t write_row(cfg_idx_t idx, logic [31:0] val);
    return '{kind: ROW_WRITE, idx: idx, val: val, pin: 1'b0, typed: 1'b0, want: '0};
  endfunction

  // Offer one sample after a random gap, hold it until taken, then log the expectation.
  // valid is left high so a zero gap on the next item keeps the channel streaming.
  task automatic send_sample(logic [31:0] now, logic pin, logic typed, result_t want);
    int      gap;
    result_t pred;
    gap = src_idle ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid     <= 1'b1;
    smp.now_ms    <= now;
    smp.pin_level <= pin;
    do @(posedge clk); while (!(smp.valid && smp.ready));
    // The mirror always advances; typed rows only replace what gets compared.
    pred = debounce_step(now, pin);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfgc.valid <= 1'b1;
    cfgc.index <= idx;
    cfgc.data  <= val;
    do @(posedge clk); while (!(cfgc.valid && cfgc.ready));
    case (idx)
      CFG_INVERT_LEVEL:  m_invert   = val[0];
      CFG_DEBOUNCE_TIME: m_debounce = val;
      CFG_HOLD_TIME:     m_hold     = val;
      default: ;
    endcase
    cfgc.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering samples and let every outstanding result come back,
  // then keep idling to cover the two-stage pipeline.
  task automatic settle();
    smp.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: random stall before each item, ready held until the handshake.
  initial begin
    int stall;
    res.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = snk_idle ? $urandom_range(0, 3) : 0;
      repeat (stall) begin
        res.ready <= 1'b0;
        @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!(res.valid && res.ready));
    end
  end

  // Scoreboard: every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && res.valid && res.ready) begin
      got = outcome(res.pressed_now, res.press_edge, res.release_edge,
                    res.held_pressed, res.held_released, res.change_time);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: pressed=%0b press=%0b rel=%0b hp=%0b hr=%0b ct=%h",
                   got.pressed_now, got.press_edge, got.release_edge,
                   got.held_pressed, got.held_released, got.change_time);
      end else begin
        want = pending_results.pop_front();
        if (got.pressed_now !== want.pressed_now || got.press_edge !== want.press_edge ||
            got.release_edge !== want.release_edge ||
            got.held_pressed !== want.held_pressed ||
            got.held_released !== want.held_released ||
            got.change_time !== want.change_time) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: exp p=%0b pe=%0b re=%0b hp=%0b hr=%0b ct=%h | got p=%0b pe=%0b re=%0b hp=%0b hr=%0b ct=%h",
                     want.pressed_now, want.press_edge, want.release_edge,
                     want.held_pressed, want.held_released, want.change_time,
                     got.pressed_now, got.press_edge, got.release_edge,
                     got.held_pressed, got.held_released, got.change_time);
        end
      end
    end
  end

  // Watchdog: generous multiple of the slowest legal run.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("button_lockout_debouncer_top verification failed");
    $finish;
  end

  // Stimulus
  initial begin
    dir_row_t    dir_rows[$];
    logic [31:0] t;
    logic        target;
    logic        pin;
    logic [31:0] deb;
    logic [31:0] hold;

    rst           <= 1'b1;
    smp.valid     <= 1'b0;
    smp.now_ms    <= '0;
    smp.pin_level <= 1'b0;
    cfgc.valid    <= 1'b0;
    cfgc.index    <= CFG_INVERT_LEVEL;
    cfgc.data     <= '0;

    // Reset state: released, change time zero, no inversion, lockout 25, hold 1000.
    m_invert   = 1'b0;
    m_debounce = DEBOUNCE_TIME_RESET;
    m_hold     = HOLD_TIME_RESET;
    m_level    = 1'b0;
    m_stamp    = '0;

    // Directed table. Comments give the behavior each group targets.
    dir_rows = '{
      // lockout right after reset (reset counts as a change at time 0)
      typed_row(32'd0,    1'b0, outcome(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0)),
      typed_row(32'd10,   1'b1, outcome(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0)),
      // lockout ends exactly at the debounce time
      typed_row(32'd25,   1'b1, outcome(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'd25)),
      typed_row(32'd30,   1'b0, outcome(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd25)),
      // held flag exactly at the hold time
      typed_row(32'd1025, 1'b1, outcome(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 32'd25)),
      typed_row(32'd1030, 1'b0, outcome(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 32'd1030)),
      // timestamp extremes and wraparound
      typed_row(32'hFFFF_FFFF, 1'b0, outcome(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 32'd1030)),
      typed_row(32'hFFFF_FFFF, 1'b1, outcome(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF)),
      typed_row(32'd5,         1'b0, outcome(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF)),
      typed_row(32'h7FFF_FFFF, 1'b0, outcome(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 32'h7FFF_FFFF)),
      // time going backwards reads as a huge elapsed time
      typed_row(32'h7FFF_FFF0, 1'b1, outcome(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'h7FFF_FFF0)),
      sample_row(32'h8000_0000, 1'b1),
      // zero debounce and zero hold
      write_row(CFG_DEBOUNCE_TIME, 32'd0),
      write_row(CFG_HOLD_TIME,     32'd0),
      typed_row(32'h7FFF_FFF0, 1'b1, outcome(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 32'h7FFF_FFF0)),
      typed_row(32'h7FFF_FFF0, 1'b0, outcome(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 32'h7FFF_FFF0)),
      // inverted pin
      write_row(CFG_INVERT_LEVEL, 32'd1),
      typed_row(32'd100, 1'b0, outcome(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 32'd100)),
      typed_row(32'd101, 1'b1, outcome(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 32'd101)),
      // undecoded index, then maximum debounce and hold
      write_row(CFG_UNUSED,        32'hA5A5_A5A5),
      write_row(CFG_DEBOUNCE_TIME, 32'hFFFF_FFFF),
      write_row(CFG_HOLD_TIME,     32'hFFFF_FFFF),
      typed_row(32'd102, 1'b0, outcome(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd101)),
      typed_row(32'd100, 1'b0, outcome(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'd100)),
      typed_row(32'd99,  1'b0, outcome(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 32'd100)),
      sample_row(32'hDEAD_BEEF, 1'b1),
      // back to reset values
      write_row(CFG_INVERT_LEVEL,  32'd0),
      write_row(CFG_DEBOUNCE_TIME, DEBOUNCE_TIME_RESET),
      write_row(CFG_HOLD_TIME,     HOLD_TIME_RESET)
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        // registers change only with the pipeline empty
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_sample(dir_rows[i].val, dir_rows[i].pin, dir_rows[i].typed, dir_rows[i].want);
      end
    end
    settle();

    // Random phases: a fresh configuration each phase, then a plausible button
    // trace (mostly small time steps, bouncing pin) with occasional jumps.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0:       deb = 32'd0;
        1, 2:    deb = $urandom_range(1, 40);
        default: deb = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0:       hold = 32'd0;
        1, 2:    hold = $urandom_range(1, 400);
        default: hold = $urandom;
      endcase
      write_reg(CFG_INVERT_LEVEL, {31'd0, 1'($urandom_range(0, 1))});
      write_reg(CFG_DEBOUNCE_TIME, deb);
      write_reg(CFG_HOLD_TIME, hold);
      // Some phases run with no gaps on one or both sides.
      src_idle = ($urandom_range(0, 2) != 0);
      snk_idle = ($urandom_range(0, 2) != 0);
      t      = $urandom;
      target = 1'($urandom_range(0, 1));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 19))
          14, 15, 16: t = t + $urandom_range(30, 1500);
          17:         t = $urandom;
          18:         t = t - $urandom_range(1, 40);
          default:    t = t + $urandom_range(0, 30);
        endcase
        if ($urandom_range(0, 15) == 0)
          target = ~target;
        // contact bounce: a quarter of the samples read a random level
        pin = ($urandom_range(0, 3) == 0) ? 1'($urandom_range(0, 1)) : target;
        send_sample(t, pin, 1'b0, '0);
      end
      settle();
    end

    if (mismatches == 0 && pending_results.size() == 0)
      $display("button_lockout_debouncer_top verification clean");
    else
      $display("button_lockout_debouncer_top verification failed");
    $finish;
  end

endmodule

`default_nettype wire
